// File: rtl/bb3_pkg.sv
`timescale 1ns / 1ps
package bb3_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_W    = 16;
   localparam int SUM_W       = 12;   // nine 8-bit samples
   localparam int COUNT_W     = 4;
   localparam int RECIP_FRAC  = 16;
   localparam int RECIP_W     = RECIP_FRAC + 1;
   localparam int SHIFT_W     = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [WIDTH_REG_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0]    FRAME_HEIGHT_RESET = 16'd768;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // [0] upper row, [1] middle row, [2] lower row
   typedef pixel_type [2:0] column_type;
   // [0] left, [1] center, [2] right
   typedef column_type [2:0] window_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_entry_type;

   // neighbors to leave out, plus the end-of-frame marker
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } nbr_flags_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic [RECIP_W-1:0] mult;
   } recip_type;

   // floor(n / (2*count)) == ((n >> shift) * mult) >> RECIP_FRAC for n < 2^13
   function automatic recip_type recip_of(logic [COUNT_W-1:0] count);
      recip_type r;
      case (count)
         4'd1:    r = '{shift: 2'd1, mult: 17'd65536};
         4'd2:    r = '{shift: 2'd2, mult: 17'd65536};
         4'd3:    r = '{shift: 2'd1, mult: 17'd21846};
         4'd4:    r = '{shift: 2'd3, mult: 17'd65536};
         4'd6:    r = '{shift: 2'd2, mult: 17'd21846};
         4'd9:    r = '{shift: 2'd1, mult: 17'd7282};
         default: r = '{shift: 2'd0, mult: 17'd65536};
      endcase
      return r;
   endfunction

endpackage

// File: rtl/bb3_if.sv
`timescale 1ns / 1ps
interface bb3_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;

   modport source (output valid, op, in_red, in_green, in_blue, input ready);
   modport sink (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       frame_last;

   modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
   modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// File: rtl/bb3_line_mem.sv
`timescale 1ns / 1ps
module bb3_line_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 48,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read during write returns the old contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bb3_average.sv
`timescale 1ns / 1ps
module bb3_average (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  bb3_pkg::nbr_flags_type in_flags,
   input  bb3_pkg::window_type    window,
   bb3_rsp_if.source              rsp_ch
);
   import bb3_pkg::*;

   localparam int NUM_W  = SUM_W + 1;
   localparam int PROD_W = NUM_W + RECIP_W;

   logic               s3_valid_ff, s3_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic               adv_out, adv3, s3_fire;
   logic [SUM_W-1:0]   sum_red, sum_green, sum_blue;
   logic [COUNT_W-1:0] count;
   logic [SUM_W-1:0]   s3_red_ff, s3_green_ff, s3_blue_ff;
   logic [COUNT_W-1:0] s3_count_ff;
   logic               s3_last_ff;
   pixel_type          out_pixel_ff;
   logic               out_last_ff;

   // rounded average: floor((2*total + count) / (2*count))
   function automatic logic [7:0] scaled_avg(logic [SUM_W-1:0] total,
                                             logic [COUNT_W-1:0] cnt);
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  x;
      logic [PROD_W-1:0] prod;
      recip_type         rc;
      rc   = recip_of(cnt);
      num  = {total, 1'b0} + NUM_W'(cnt);
      x    = num >> rc.shift;
      prod = PROD_W'(x) * PROD_W'(rc.mult);
      return prod[RECIP_FRAC +: 8];
   endfunction

   assign adv_out  = !out_valid_ff || rsp_ch.ready;
   assign adv3     = !s3_valid_ff || adv_out;
   assign s3_fire  = s3_valid_ff && adv_out;
   assign in_ready = adv3;

   always_comb begin
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      count     = '0;
      for (int dc = 0; dc < 3; dc++) begin
         for (int dr = 0; dr < 3; dr++) begin
            if (!((dr == 0 && in_flags.top) || (dr == 2 && in_flags.bottom) ||
                  (dc == 0 && in_flags.left) || (dc == 2 && in_flags.right))) begin
               sum_red   = sum_red + SUM_W'(window[dc][dr].red);
               sum_green = sum_green + SUM_W'(window[dc][dr].green);
               sum_blue  = sum_blue + SUM_W'(window[dc][dr].blue);
               count     = count + COUNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      s3_valid_in  = adv3 ? in_valid : s3_valid_ff;
      out_valid_in = adv_out ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && adv3) begin
         s3_red_ff   <= sum_red;
         s3_green_ff <= sum_green;
         s3_blue_ff  <= sum_blue;
         s3_count_ff <= count;
         s3_last_ff  <= in_flags.last;
      end
      if (s3_fire) begin
         out_pixel_ff.red   <= scaled_avg(s3_red_ff, s3_count_ff);
         out_pixel_ff.green <= scaled_avg(s3_green_ff, s3_count_ff);
         out_pixel_ff.blue  <= scaled_avg(s3_blue_ff, s3_count_ff);
         out_last_ff        <= s3_last_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_red    = out_pixel_ff.red;
   assign rsp_ch.out_green  = out_pixel_ff.green;
   assign rsp_ch.out_blue   = out_pixel_ff.blue;
   assign rsp_ch.frame_last = out_last_ff;

`ifndef SYNTHESIS
   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_count_ff == 4'd1 || s3_count_ff == 4'd2 || s3_count_ff == 4'd3 ||
                       s3_count_ff == 4'd4 || s3_count_ff == 4'd6 || s3_count_ff == 4'd9))
      else $error("neighbor count outside the possible set");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_red_ff <= SUM_W'(s3_count_ff) * SUM_W'(255) &&
                       s3_green_ff <= SUM_W'(s3_count_ff) * SUM_W'(255) &&
                       s3_blue_ff <= SUM_W'(s3_count_ff) * SUM_W'(255)))
      else $error("channel total exceeds count times full scale");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !adv_out |=> s3_valid_ff && $stable(s3_red_ff) &&
                                  $stable(s3_count_ff) && $stable(s3_last_ff))
      else $error("sum stage changed while output stalled");
`endif

endmodule

// File: rtl/box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
// 3x3 box blur with edge-aware averaging over an RGB frame in raster order.
// req_ch carries pixels (op = pixel) and flush ticks (op = flush); rsp_ch
// returns one averaged pixel per result, frame_last marking the frame's final
// pixel. Both channels move a request when valid and ready are high together.
// Results trail their pixels by one row plus one pixel of requests; after the
// frame's last pixel, width + 1 further requests (flush or pixel) drain the
// rest. Flush ticks that arrive while pixels are still due are dropped.
// Once a request produces a result, it passes the s1, s2, s3 and output
// registers to rsp_ch. One request per clock is sustained while rsp_ch is
// ready: the line memory does one read and one write each cycle, with a bypass
// when the write and the next read hit the same column (one-pixel-wide frames).
// csr_write_en/csr_index/csr_data set frame_width (0) and frame_height (1);
// any such write restarts the frame. Write only while the block is idle.
// Reset clears the counters and pipeline and sets width 1024 (clamped to
// MAX_WIDTH) and height 768; the line memory is not cleared.
// When rsp_ch stalls, the pipeline stages fill and req_ch.ready drops.
module box_blur_3x3_edge_aware #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   bb3_req_if.sink                          req_ch,
   bb3_rsp_if.source                        rsp_ch,
   input  logic                             csr_write_en,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bb3_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int EFW = $clog2(MAX_WIDTH + 1);
   localparam int LW  = $bits(line_entry_type);

   logic [EFW-1:0]      eff_w_ff, eff_w_in;
   logic [HEIGHT_W-1:0] eff_h_ff, eff_h_in;
   logic [CW-1:0]       in_col_ff, in_col_in;
   logic [HEIGHT_W-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]       out_c_ff, out_c_in;
   logic [HEIGHT_W-1:0] out_r_ff, out_r_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   window_type          win_ff, win_in;

   logic                s1_primed_ff;
   logic [CW-1:0]       s1_col_ff;
   pixel_type           s1_pixel_ff;
   nbr_flags_type       s1_flags_ff;
   nbr_flags_type       s2_flags_ff;
   logic                fwd_hit_ff;
   line_entry_type      fwd_data_ff;

   logic                cfg_hit;
   logic                take, drain, accept_eff, primed, col_is_end;
   logic [HEIGHT_W-1:0] row_cap;
   nbr_flags_type       out_flags;
   pixel_type           pixel_in;
   logic                s2_ready, adv2, s1_fire;
   logic [LW-1:0]       mem_rd_data;
   line_entry_type      line, wr_data;

   function automatic logic [EFW-1:0] clamp_width(logic [WIDTH_REG_W-1:0] v);
      logic [EFW-1:0] w;
      if (v == '0) begin
         w = EFW'(1);
      end else if (32'(v) > 32'(MAX_WIDTH)) begin
         w = EFW'(MAX_WIDTH);
      end else begin
         w = EFW'(v);
      end
      return w;
   endfunction

   // ---- request side ----
   assign take       = req_ch.valid && req_ch.ready;
   assign drain      = in_row_ff >= eff_h_ff;
   assign accept_eff = take && !(op_type'(req_ch.op) == OP_FLUSH && !drain);
   assign row_cap    = (eff_h_ff > 16'd2) ? eff_h_ff : 16'd2;
   assign col_is_end = EFW'(in_col_ff) == eff_w_ff - EFW'(1);
   assign primed     = (in_row_ff >= 16'd2) || (in_row_ff == 16'd1 && in_col_ff != '0);

   always_comb begin
      pixel_in = '0;
      if (!drain) begin
         pixel_in.red   = req_ch.in_red;
         pixel_in.green = req_ch.in_green;
         pixel_in.blue  = req_ch.in_blue;
      end
   end

   // position of the pixel whose result the request produces
   always_comb begin
      out_flags.top    = out_r_ff == '0;
      out_flags.bottom = out_r_ff >= eff_h_ff - 16'd1;
      out_flags.left   = out_c_ff == '0;
      out_flags.right  = EFW'(out_c_ff) == eff_w_ff - EFW'(1);
      out_flags.last   = (out_r_ff == eff_h_ff - 16'd1) && out_flags.right;
   end

   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      cfg_hit  = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               eff_w_in = clamp_width(csr_data[WIDTH_REG_W-1:0]);
               cfg_hit  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               eff_h_in = (csr_data[HEIGHT_W-1:0] == '0) ? HEIGHT_W'(1)
                                                         : csr_data[HEIGHT_W-1:0];
               cfg_hit  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_c_in  = out_c_ff;
      out_r_in  = out_r_ff;
      if (cfg_hit) begin
         in_col_in = '0;
         in_row_in = '0;
         out_c_in  = '0;
         out_r_in  = '0;
      end else if (accept_eff) begin
         if (col_is_end) begin
            in_col_in = '0;
            if (in_row_ff < row_cap) begin
               in_row_in = in_row_ff + 16'd1;
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (primed) begin
            if (out_flags.last) begin
               in_col_in = '0;
               in_row_in = '0;
               out_c_in  = '0;
               out_r_in  = '0;
            end else if (out_flags.right) begin
               out_c_in = '0;
               out_r_in = out_r_ff + 16'd1;
            end else begin
               out_c_in = out_c_ff + CW'(1);
            end
         end
      end
   end

   // ---- pipeline control ----
   assign adv2         = !s2_valid_ff || s2_ready;
   assign s1_fire      = s1_valid_ff && adv2;
   assign req_ch.ready = !s1_valid_ff || s1_fire;

   // bypass when the previous write landed on the column read in the same cycle
   assign line    = fwd_hit_ff ? fwd_data_ff : line_entry_type'(mem_rd_data);
   assign wr_data = '{upper: line.middle, middle: s1_pixel_ff};

   always_comb begin
      s1_valid_in = req_ch.ready ? accept_eff : s1_valid_ff;
      s2_valid_in = adv2 ? (s1_fire && s1_primed_ff) : s2_valid_ff;
      win_in      = win_ff;
      if (s1_fire) begin
         win_in[0]    = win_ff[1];
         win_in[1]    = win_ff[2];
         win_in[2][0] = line.upper;
         win_in[2][1] = line.middle;
         win_in[2][2] = s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff    <= clamp_width(FRAME_WIDTH_RESET);
         eff_h_ff    <= FRAME_HEIGHT_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_c_ff    <= '0;
         out_r_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_c_ff    <= out_c_in;
         out_r_ff    <= out_r_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_eff) begin
         s1_col_ff    <= in_col_ff;
         s1_pixel_ff  <= pixel_in;
         s1_primed_ff <= primed;
         s1_flags_ff  <= out_flags;
         fwd_hit_ff   <= s1_fire && (s1_col_ff == in_col_ff);
         fwd_data_ff  <= wr_data;
      end
      if (s1_fire) begin
         s2_flags_ff <= s1_flags_ff;
      end
   end

   bb3_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (LW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept_eff),
      .rd_addr (in_col_ff),
      .rd_data (mem_rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   bb3_average u_average (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_ready (s2_ready),
      .in_flags (s2_flags_ff),
      .window   (win_ff),
      .rsp_ch   (rsp_ch)
   );

`ifndef SYNTHESIS
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ready |=> $stable(win_ff))
      else $error("window shifted under a stalled result");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      EFW'(in_col_ff) < eff_w_ff && EFW'(out_c_ff) < eff_w_ff)
      else $error("column counter beyond frame width");

   a_row_cap: assert property (@(posedge clock) disable iff (reset)
      in_row_ff <= row_cap && out_r_ff < eff_h_ff)
      else $error("row counter beyond its limit");
`endif

endmodule

// File: verif/tb_box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
module tb_box_blur_3x3_edge_aware;
   import bb3_pkg::*;

   localparam int MAX_W        = 1024;
   localparam int SETTLE       = 8;
   localparam int END_TAIL     = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int BIG_FRAME    = 300;
   localparam int RANDOM_ITEMS = 1050;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      pixel_type avg;
      logic      last;
   } blurred_type;

   typedef enum logic [1:0] {
      ROW_PIXEL,
      ROW_FLUSH,
      ROW_WRITE
   } row_kind_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_PATTERN,
      RX_MOSTLY
   } stall_mode_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      pixel_type              px;
      logic [11:0]            reps;
      logic                   typed;
      pixel_type              exp_px;
      logic                   exp_last;
   } directed_row_type;

   localparam pixel_type NO_PX = '0;
   localparam int DIR_ROWS = 24;

   // typed rows: every result caused by the row's requests must equal exp_px/exp_last
   localparam directed_row_type DIRECTED [DIR_ROWS] = '{
      // 4x2, flat black
      '{ROW_WRITE, REG_FRAME_WIDTH, 16'd4, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 16'd2, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_PIXEL, 2'd0, 16'd0, 24'h000000, 12'd8, 1'b1, 24'h000000, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd4, 1'b1, 24'h000000, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd1, 1'b1, 24'h000000, 1'b1},
      // zero registers read as a 1x1 frame
      '{ROW_WRITE, REG_FRAME_WIDTH, 16'd0, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 16'd0, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_PIXEL, 2'd0, 16'd0, 24'hFF00FF, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd2, 1'b1, 24'hFF00FF, 1'b1},
      '{ROW_PIXEL, 2'd0, 16'd0, 24'h00FF00, 12'd1, 1'b0, NO_PX, 1'b0},
      // pixels during drain act as flush ticks
      '{ROW_PIXEL, 2'd0, 16'd0, 24'h070707, 12'd2, 1'b1, 24'h00FF00, 1'b1},
      // flat white 3x3
      '{ROW_WRITE, REG_FRAME_WIDTH, 16'd3, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 16'd3, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_PIXEL, 2'd0, 16'd0, 24'hFFFFFF, 12'd9, 1'b1, 24'hFFFFFF, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd3, 1'b1, 24'hFFFFFF, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd1, 1'b1, 24'hFFFFFF, 1'b1},
      // 2x1: two-pixel averages, halves round up
      '{ROW_WRITE, REG_FRAME_WIDTH, 16'd2, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_WRITE, REG_FRAME_HEIGHT, 16'd1, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_PIXEL, 2'd0, 16'd0, 24'h0000FF, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_PIXEL, 2'd0, 16'd0, 24'h010100, 12'd1, 1'b0, NO_PX, 1'b0},
      // unknown index mid-frame must not restart it
      '{ROW_WRITE, REG_UNUSED, 16'hFFFF, NO_PX, 12'd1, 1'b0, NO_PX, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd2, 1'b1, 24'h010180, 1'b0},
      '{ROW_FLUSH, 2'd0, 16'd0, NO_PX, 12'd1, 1'b1, 24'h010180, 1'b1}
   };

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   bb3_req_if req_if ();
   bb3_rsp_if rsp_if ();

   box_blur_3x3_edge_aware u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_if),
      .rsp_ch       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // blur predictor state
   pixel_type               older_row [MAX_W];
   pixel_type               newer_row [MAX_W];
   window_type              nbhd;
   int unsigned             pred_col;
   int unsigned             pred_row;
   int unsigned             emitted;
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0]     height_reg;

   blurred_type pending_blur [$];
   blurred_type want;
   int unsigned fail_count = 0;
   int unsigned counted;
   int unsigned burst_left;
   int unsigned cycle_count = 0;

   int unsigned hold_requests;
   int unsigned hold_served;
   int unsigned hold_left;
   int unsigned rx_left;
   int unsigned rx_tick;
   stall_mode_type rx_mode;

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg == 0) ? 1 : 32'(height_reg);
   endfunction

   function automatic void rewind_frame();
      pred_col = 0;
      pred_row = 0;
      emitted  = 0;
   endfunction

   function automatic pixel_type rand_pixel();
      logic [23:0] v;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 7))
            0: v[i*8 +: 8] = 8'h00;
            1: v[i*8 +: 8] = 8'hFF;
            default: v[i*8 +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      return pixel_type'(v);
   endfunction

   task automatic compute_blur(input op_type op, input pixel_type px, output bit ignored,
                               output bit made, output blurred_type res);
      int unsigned w, h, row_cap, col, k, r, c, cnt, tr, tg, tb;
      bit drain, primed;
      pixel_type up, mid, cur, p;
      w = eff_width();
      h = eff_height();
      row_cap = (h > 2) ? h : 2;
      drain = (pred_row >= h);
      ignored = (op == OP_FLUSH) && !drain;
      made = 1'b0;
      res = '0;
      if (!ignored) begin
         cur = drain ? NO_PX : px;
         col = (pred_col >= w) ? 0 : pred_col;
         up = older_row[col];
         mid = newer_row[col];
         older_row[col] = mid;
         newer_row[col] = cur;
         nbhd[0] = nbhd[1];
         nbhd[1] = nbhd[2];
         nbhd[2][0] = up;
         nbhd[2][1] = mid;
         nbhd[2][2] = cur;
         primed = (pred_row >= 2) || (pred_row == 1 && col >= 1);
         col++;
         if (col >= w) begin
            col = 0;
            if (pred_row < row_cap) pred_row++;
         end
         pred_col = col;
         if (primed) begin
            // the window center is output pixel k; skip neighbors off the frame
            k = emitted;
            r = k / w;
            c = k % w;
            cnt = 0;
            tr = 0;
            tg = 0;
            tb = 0;
            for (int dr = 0; dr < 3; dr++) begin
               for (int dc = 0; dc < 3; dc++) begin
                  if (!(dr == 0 && r == 0) && !(dr == 2 && r + 1 >= h) &&
                      !(dc == 0 && c == 0) && !(dc == 2 && c + 1 >= w)) begin
                     p = nbhd[dc][dr];
                     tr += 32'(p.red);
                     tg += 32'(p.green);
                     tb += 32'(p.blue);
                     cnt++;
                  end
               end
            end
            res.avg.red   = 8'((2 * tr + cnt) / (2 * cnt));
            res.avg.green = 8'((2 * tg + cnt) / (2 * cnt));
            res.avg.blue  = 8'((2 * tb + cnt) / (2 * cnt));
            res.last = (k + 1 == h * w);
            made = 1'b1;
            emitted = k + 1;
            if (res.last) rewind_frame();
         end
      end
   endtask

   // called at a clock edge; returns at the edge that accepted the request
   task automatic push_request(input op_type op, input pixel_type px, input bit typed,
                               input blurred_type typed_res);
      int unsigned gap;
      bit ignored, made;
      blurred_type res;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 200);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
         end
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.in_red   <= px.red;
      req_if.in_green <= px.green;
      req_if.in_blue  <= px.blue;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      compute_blur(op, px, ignored, made, res);
      if (made) pending_blur.push_back(typed ? typed_res : res);
      if (!ignored) counted++;
   endtask

   // stop offering, wait for every expected result, then let the pipeline empty
   task automatic quiesce(input int unsigned tail);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_blur.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      if (idx == REG_FRAME_WIDTH) begin
         width_reg = data[WIDTH_REG_W-1:0];
         rewind_frame();
      end else if (idx == REG_FRAME_HEIGHT) begin
         height_reg = data[HEIGHT_W-1:0];
         rewind_frame();
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_v, act_v);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count > CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_blur.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected result, expected none, actual %h last %b",
                     $time, {rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue},
                     rsp_if.frame_last);
         end else begin
            want = pending_blur.pop_front();
            check_field("out_red", 32'(want.avg.red), 32'(rsp_if.out_red));
            check_field("out_green", 32'(want.avg.green), 32'(rsp_if.out_green));
            check_field("out_blue", 32'(want.avg.blue), 32'(rsp_if.out_blue));
            check_field("frame_last", 32'(want.last), 32'(rsp_if.frame_last));
         end
      end
   end

   // receiver back-pressure, with a long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      hold_served = 0;
      hold_left = 0;
      rx_left = 0;
      rx_tick = 0;
      rx_mode = RX_OPEN;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (rx_left == 0) begin
            rx_mode = stall_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
         end
         rx_left--;
         rx_tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:    rsp_if.ready <= 1'b1;
               RX_COIN:    rsp_if.ready <= ($urandom_range(0, 1) == 1);
               RX_PATTERN: rsp_if.ready <= ((rx_tick % 5) < 2);
               default:    rsp_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      directed_row_type row;
      blurred_type   typed_res;
      op_type        op;
      int unsigned   phase, w_val, h_val, npx, cut, frames;
      bit            forced;
      logic [CSR_DATA_W-1:0] w_data, h_data;

      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_if.valid    = 1'b0;
      req_if.op       = OP_PIXEL;
      req_if.in_red   = '0;
      req_if.in_green = '0;
      req_if.in_blue  = '0;
      counted         = 0;
      burst_left      = 0;
      hold_requests   = 0;
      nbhd            = '0;
      width_reg       = FRAME_WIDTH_RESET;
      height_reg      = FRAME_HEIGHT_RESET;
      rewind_frame();
      for (int i = 0; i < MAX_W; i++) begin
         older_row[i] = NO_PX;
         newer_row[i] = NO_PX;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_WRITE) begin
            quiesce(SETTLE);
            write_reg(row.idx, row.data);
         end else begin
            op = (row.kind == ROW_FLUSH) ? OP_FLUSH : OP_PIXEL;
            typed_res = {row.exp_px, row.exp_last};
            for (int n = 0; n < row.reps; n++)
               push_request(op, row.px, row.typed, typed_res);
         end
      end

      counted = 0;
      phase = 0;
      typed_res = '0;
      while (counted < RANDOM_ITEMS) begin
         phase++;
         forced = (phase == 2 || phase == 15);
         quiesce(SETTLE);
         if (forced) begin
            w_val = 10;
            h_val = 6;
         end else if ($urandom_range(0, 4) != 0) begin
            w_val = $urandom_range(1, 12);
            h_val = $urandom_range(1, 6);
         end else begin
            case ($urandom_range(0, 6))
               0: w_val = 0;
               1: w_val = 1;
               2: w_val = 1023;
               3: w_val = 1024;
               4: w_val = $urandom_range(1025, 2047);
               5: w_val = 2047;
               default: w_val = $urandom_range(13, 64);
            endcase
            case ($urandom_range(0, 4))
               0: h_val = 0;
               1: h_val = 1;
               2: h_val = 2;
               3: h_val = 65535;
               default: h_val = $urandom_range(7, 40);
            endcase
         end
         // width writes carry junk above the register's 11 bits
         w_data = {5'($urandom_range(0, 31)), 11'(w_val)};
         h_data = 16'(h_val);
         case (forced ? 0 : $urandom_range(0, 3))
            0: begin
               write_reg(REG_FRAME_WIDTH, w_data);
               write_reg(REG_FRAME_HEIGHT, h_data);
            end
            1: begin
               write_reg(REG_FRAME_HEIGHT, h_data);
               write_reg(REG_FRAME_WIDTH, w_data);
            end
            2: write_reg(REG_FRAME_WIDTH, w_data);
            default: write_reg(REG_FRAME_HEIGHT, h_data);
         endcase
         if (forced) hold_requests++;

         npx = eff_width() * eff_height();
         frames = (npx > BIG_FRAME) ? 1 : $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            if (npx > BIG_FRAME)
               cut = $urandom_range(20, 120);
            else if ($urandom_range(0, 9) == 0)
               cut = $urandom_range(0, npx - 1);
            else
               cut = npx;
            for (int n = 0; n < cut; n++) begin
               if ($urandom_range(0, 11) == 0)
                  push_request(OP_FLUSH, rand_pixel(), 1'b0, typed_res);
               if ((forced && n == 30) || $urandom_range(0, 59) == 0)
                  quiesce(0);
               push_request(OP_PIXEL, rand_pixel(), 1'b0, typed_res);
            end
            if (cut < npx) break;
            for (int n = 0; n <= eff_width(); n++) begin
               op = ($urandom_range(0, 3) != 0) ? OP_FLUSH : OP_PIXEL;
               push_request(op, rand_pixel(), 1'b0, typed_res);
            end
         end
      end

      quiesce(END_TAIL);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: box_blur_3x3_edge_aware.f
rtl/bb3_pkg.sv
rtl/bb3_if.sv
rtl/bb3_line_mem.sv
rtl/bb3_average.sv
rtl/box_blur_3x3_edge_aware.sv
verif/tb_box_blur_3x3_edge_aware.sv
